### hdl/rot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rot_pkg: shared types and constants of the range owner table
// Table sizing, entry and request layouts, result codes and owner conversion.
// ----------------------------------------------------------------------------
package rot_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int OWNER_BITS  = 16;
   localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_OVERLAP = 2'd2,
      STATUS_FULL    = 2'd3
   } rot_status_type;

   typedef enum logic {
      FUNC_ADD  = 1'b0,
      FUNC_FIND = 1'b1
   } rot_func_type;

   // One stored region. Ends are exclusive and never pass 2^32-1 once stored,
   // so 32 bits hold them.
   typedef struct packed {
      logic [31:0]           region_namespace;
      logic [31:0]           layer_start;
      logic [31:0]           layer_stop;
      logic [31:0]           expert_start;
      logic [31:0]           expert_stop;
      logic [OWNER_BITS-1:0] owner;
   } rot_entry_type;

   localparam int ENTRY_BITS = $bits(rot_entry_type);

   typedef struct packed {
      rot_func_type func;
      logic [31:0]  region_namespace;
      logic [31:0]  layer_start;
      logic [31:0]  layer_span;
      logic [31:0]  expert_start;
      logic [31:0]  expert_span;
      logic [15:0]  owner_id;
      logic         owner_usable;
      logic [31:0]  key_layer;
      logic [31:0]  key_expert;
   } rot_req_type;

   typedef struct packed {
      rot_status_type status;
      logic           found;
      logic [15:0]    found_owner;
   } rot_rsp_type;

   // Keeps the low OWNER_BITS bits of a 16-bit owner id.
   function automatic logic [OWNER_BITS-1:0] owner_from_id(input logic [15:0] id);
      logic [31:0]           wide;
      logic [OWNER_BITS-1:0] res;
      wide = {16'd0, id};
      res  = wide[OWNER_BITS-1:0];
      return res;
   endfunction

   // Widens or cuts a stored owner to the 16-bit result field.
   function automatic logic [15:0] owner_to_id(input logic [OWNER_BITS-1:0] own);
      logic [31:0] wide;
      wide = 32'd0;
      wide[OWNER_BITS-1:0] = own;
      return wide[15:0];
   endfunction

endpackage
`default_nettype wire

### hdl/range_owner_table.sv
`default_nettype none
// A word's scan stops at the first stored region that hits; without a hit all stored
// regions are read (none when the table is empty), and an invalid add skips the scan.
// The engine takes a new word only once its last result has moved to the output register;
// the scan reads one table entry a cycle from a single synchronous RAM read port.
// Reset (synchronous, active high) clears the fill count; the RAM is never read unwritten.
// ----------------------------------------------------------------------------
// range_owner_table: table of two-dimensional owner regions
// Adds non-overlapping regions per namespace and finds the owner of a key.
// ----------------------------------------------------------------------------
module range_owner_table
   import rot_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: region_namespace[31:0], layer_start[63:32],
   // layer_span[95:64], expert_start[127:96], expert_span[159:128],
   // owner_id[175:160], owner_usable[176], key_layer[208:177],
   // key_expert[240:209], zero fill[247:241].
   input  wire logic [247:0] req_tdata,
   // tuser: func[0] (0 add region, 1 find owner of key).
   input  wire logic         req_tuser,
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: status[1:0], found[2], found_owner[18:3], zero fill[23:19].
   output logic [23:0]       rsp_tdata
);

   rot_req_type req;
   logic        eng_valid;
   logic        eng_ready;
   rot_rsp_type eng_rsp;

   logic        rsp_valid_ff, rsp_valid_in;
   rot_rsp_type rsp_data_ff, rsp_data_in;

   // Unpack the request word into its fields.
   always_comb begin
      req.func             = rot_func_type'(req_tuser);
      req.region_namespace = req_tdata[31:0];
      req.layer_start      = req_tdata[63:32];
      req.layer_span       = req_tdata[95:64];
      req.expert_start     = req_tdata[127:96];
      req.expert_span      = req_tdata[159:128];
      req.owner_id         = req_tdata[175:160];
      req.owner_usable     = req_tdata[176];
      req.key_layer        = req_tdata[208:177];
      req.key_expert       = req_tdata[240:209];
   end

   rot_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_rsp)
   );

   // The output register holds a finished word while the engine already takes
   // and works on the next request; the engine only stalls when it finishes
   // another result before this one has been taken.
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_ready) begin
         rsp_valid_in = eng_valid;
         if (eng_valid) begin
            rsp_data_in = eng_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.found_owner, rsp_data_ff.found,
                        rsp_data_ff.status};

endmodule
`default_nettype wire

### hdl/rot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rot_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rot_ram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/rot_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rot_engine: region check, table scan and append
// Takes one request, scans the stored regions one a cycle and holds a result.
// ----------------------------------------------------------------------------
module rot_engine
   import rot_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire rot_req_type req,
   output logic             res_valid,
   input  wire logic        res_ready,
   output rot_rsp_type      res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   rot_req_type          cur_ff, cur_in;
   logic [31:0]          layer_stop_ff, layer_stop_in;
   logic [31:0]          expert_stop_ff, expert_stop_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [FILL_BITS-1:0] addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   rot_rsp_type          res_ff, res_in;

   logic [32:0]          layer_sum;
   logic [32:0]          expert_sum;
   logic                 bad_region;
   logic                 rd_en;
   rot_entry_type        rd_entry;
   logic [ENTRY_BITS-1:0] rd_bits;
   logic                 same_ns;
   logic                 hit;
   logic                 wr_en;
   rot_entry_type        wr_entry;

   rot_ram #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_BITS-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[ADDR_BITS-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_entry = rot_entry_type'(rd_bits);

   assign layer_sum  = {1'b0, req.layer_start} + {1'b0, req.layer_span};
   assign expert_sum = {1'b0, req.expert_start} + {1'b0, req.expert_span};
   assign bad_region = (req.region_namespace == 32'd0) || (req.layer_span == 32'd0) ||
                       (req.expert_span == 32'd0) || !req.owner_usable ||
                       layer_sum[32] || expert_sum[32];

   // Find looks for a containing region, add for any shared layer and expert.
   assign same_ns = (rd_entry.region_namespace == cur_ff.region_namespace);
   always_comb begin
      if (cur_ff.func == FUNC_FIND) begin
         hit = same_ns &&
               (cur_ff.key_layer >= rd_entry.layer_start) &&
               (cur_ff.key_layer < rd_entry.layer_stop) &&
               (cur_ff.key_expert >= rd_entry.expert_start) &&
               (cur_ff.key_expert < rd_entry.expert_stop);
      end else begin
         hit = same_ns &&
               (cur_ff.layer_start < rd_entry.layer_stop) &&
               (rd_entry.layer_start < layer_stop_ff) &&
               (cur_ff.expert_start < rd_entry.expert_stop) &&
               (rd_entry.expert_start < expert_stop_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // Only entries below the fill count are read, so the append at the fill
   // index never meets a read of the same entry.
   assign wr_en = (state_ff == ST_DONE) && res_ready && (cur_ff.func == FUNC_ADD) &&
                  (res_ff.status == STATUS_OK);
   always_comb begin
      wr_entry.region_namespace = cur_ff.region_namespace;
      wr_entry.layer_start      = cur_ff.layer_start;
      wr_entry.layer_stop       = layer_stop_ff;
      wr_entry.expert_start     = cur_ff.expert_start;
      wr_entry.expert_stop      = expert_stop_ff;
      wr_entry.owner            = owner_from_id(cur_ff.owner_id);
   end

   assign rd_en = (state_ff == ST_SCAN) && (addr_ff < fill_ff);

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      layer_stop_in  = layer_stop_ff;
      expert_stop_in = expert_stop_ff;
      fill_in        = fill_ff;
      addr_in        = addr_ff;
      pend_in        = 1'b0;
      res_in         = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in             = req;
               layer_stop_in      = layer_sum[31:0];
               expert_stop_in     = expert_sum[31:0];
               addr_in            = '0;
               res_in.status      = STATUS_OK;
               res_in.found       = 1'b0;
               res_in.found_owner = 16'd0;
               if ((req.func == FUNC_ADD) && bad_region) begin
                  res_in.status = STATUS_INVALID;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               addr_in = addr_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && hit) begin
               state_in = ST_DONE;
               if (cur_ff.func == FUNC_FIND) begin
                  res_in.found       = 1'b1;
                  res_in.found_owner = owner_to_id(rd_entry.owner);
               end else begin
                  res_in.status = STATUS_OVERLAP;
               end
            end else if (!pend_ff && (addr_ff == fill_ff)) begin
               state_in = ST_DONE;
               if ((cur_ff.func == FUNC_ADD) && (fill_ff == FILL_BITS'(TABLE_DEPTH))) begin
                  res_in.status = STATUS_FULL;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
               if (wr_en) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      layer_stop_ff  <= layer_stop_in;
      expert_stop_ff <= expert_stop_in;
      addr_ff        <= addr_in;
      res_ff         <= res_in;
   end

endmodule
`default_nettype wire

### dv/range_owner_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_owner_table_tb: self-checking bench for the range owner table
// Streams add and find words through the block while both sides idle at
// random. A behavioural copy of the region table predicts every response word,
// and the bench compares each response with that prediction field by field.
// ----------------------------------------------------------------------------
module range_owner_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rot_pkg::*;

   // The longest quiet stretch is the deliberate response hold plus one scan,
   // so this limit leaves a wide margin over any correct run.
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4 + TABLE_DEPTH + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [31:0] OWNER_KEEP = 32'((64'd1 << OWNER_BITS) - 64'd1);
   localparam logic [32:0] END_LIMIT  = 33'h0_FFFF_FFFF;

   // Ways in which the response side takes words.
   typedef enum int {
      PACE_ALWAYS,
      PACE_COIN,
      PACE_SPARSE,
      PACE_PERIODIC
   } pace_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [247:0] req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;

   // Behavioural copy of the region table. Entries below region_count are the
   // stored regions, in the order in which they were added.
   logic [31:0] region_ns       [TABLE_DEPTH];
   logic [31:0] region_layer_lo [TABLE_DEPTH];
   logic [32:0] region_layer_hi [TABLE_DEPTH];
   logic [31:0] region_expert_lo[TABLE_DEPTH];
   logic [32:0] region_expert_hi[TABLE_DEPTH];
   logic [31:0] region_owner    [TABLE_DEPTH];
   int          region_count = 0;

   rot_rsp_type lookup_results_q[$];
   int          mismatch_count = 0;

   // Sender pacing: words left in the current burst, and a switch that keeps
   // the sender offering words back to back.
   int burst_left    = 0;
   bit steady_sender = 1'b0;

   // Receiver pacing. A test asks for a long hold through hold_request; the
   // receiver process takes it over and counts it down itself.
   int       hold_request = 0;
   int       hold_left    = 0;
   int       pace_left    = 0;
   pace_type pace_mode    = PACE_ALWAYS;
   int       quiet_cycles = 0;

   range_owner_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one word to the table copy and returns the response it must give.
   function automatic rot_rsp_type table_step(input rot_req_type item);
      rot_rsp_type res;
      logic [32:0] layer_hi;
      logic [32:0] expert_hi;
      logic        clash;
      logic        hit;
      res.status      = STATUS_OK;
      res.found       = 1'b0;
      res.found_owner = 16'd0;
      if (item.func == FUNC_ADD) begin
         layer_hi  = {1'b0, item.layer_start} + {1'b0, item.layer_span};
         expert_hi = {1'b0, item.expert_start} + {1'b0, item.expert_span};
         if (item.region_namespace == 32'd0 || item.layer_span == 32'd0 ||
             item.expert_span == 32'd0 || !item.owner_usable ||
             layer_hi > END_LIMIT || expert_hi > END_LIMIT) begin
            res.status = STATUS_INVALID;
         end else begin
            clash = 1'b0;
            for (int i = 0; i < region_count; i++) begin
               if (region_ns[i] == item.region_namespace &&
                   {1'b0, item.layer_start} < region_layer_hi[i] &&
                   {1'b0, region_layer_lo[i]} < layer_hi &&
                   {1'b0, item.expert_start} < region_expert_hi[i] &&
                   {1'b0, region_expert_lo[i]} < expert_hi) begin
                  clash = 1'b1;
               end
            end
            if (clash) begin
               res.status = STATUS_OVERLAP;
            end else if (region_count >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               region_ns[region_count]        = item.region_namespace;
               region_layer_lo[region_count]  = item.layer_start;
               region_layer_hi[region_count]  = layer_hi;
               region_expert_lo[region_count] = item.expert_start;
               region_expert_hi[region_count] = expert_hi;
               region_owner[region_count]     = {16'd0, item.owner_id} & OWNER_KEEP;
               region_count++;
            end
         end
      end else begin
         // The lowest-indexed containing region wins.
         hit = 1'b0;
         for (int i = 0; i < region_count && !hit; i++) begin
            if (region_ns[i] == item.region_namespace &&
                {1'b0, item.key_layer} >= {1'b0, region_layer_lo[i]} &&
                {1'b0, item.key_layer} < region_layer_hi[i] &&
                {1'b0, item.key_expert} >= {1'b0, region_expert_lo[i]} &&
                {1'b0, item.key_expert} < region_expert_hi[i]) begin
               hit             = 1'b1;
               res.found       = 1'b1;
               res.found_owner = region_owner[i][15:0];
            end
         end
      end
      return res;
   endfunction

   function automatic rot_req_type random_word();
      rot_req_type w;
      w.func             = rot_func_type'($urandom_range(0, 1));
      w.region_namespace = $urandom();
      w.layer_start      = $urandom();
      w.layer_span       = $urandom();
      w.expert_start     = $urandom();
      w.expert_span      = $urandom();
      w.owner_id         = 16'($urandom());
      w.owner_usable     = 1'($urandom());
      w.key_layer        = $urandom();
      w.key_expert       = $urandom();
      return w;
   endfunction

   // Fields that an add does not use keep random values.
   function automatic rot_req_type add_word(input logic [31:0] ns,
                                            input logic [31:0] ls, input logic [31:0] lspan,
                                            input logic [31:0] es, input logic [31:0] espan,
                                            input logic [15:0] owner, input logic usable);
      rot_req_type w;
      w                  = random_word();
      w.func             = FUNC_ADD;
      w.region_namespace = ns;
      w.layer_start      = ls;
      w.layer_span       = lspan;
      w.expert_start     = es;
      w.expert_span      = espan;
      w.owner_id         = owner;
      w.owner_usable     = usable;
      return w;
   endfunction

   function automatic rot_req_type find_word(input logic [31:0] ns,
                                             input logic [31:0] kl, input logic [31:0] ke);
      rot_req_type w;
      w                  = random_word();
      w.func             = FUNC_FIND;
      w.region_namespace = ns;
      w.key_layer        = kl;
      w.key_expert       = ke;
      return w;
   endfunction

   // A key coordinate on, just outside or inside the span [lo, hi).
   function automatic logic [31:0] key_near(input logic [31:0] lo, input logic [32:0] hi);
      longint unsigned width;
      logic [31:0]     k;
      width = 64'(hi) - 64'(lo);
      case ($urandom_range(0, 4))
         0: k = lo;
         1: k = 32'(64'(hi) - 64'd1);
         2: k = hi[31:0];
         3: k = lo - 32'd1;
         default: k = 32'(64'(lo) + (64'($urandom()) % width));
      endcase
      return k;
   endfunction

   // Offers one word, waits for the handshake and records its response. After
   // the word the sender either carries on with its burst, keeping tvalid
   // high, or drops tvalid for a random gap.
   task automatic send_word(input rot_req_type item);
      req_tdata  <= {7'd0, item.key_expert, item.key_layer, item.owner_usable,
                     item.owner_id, item.expert_span, item.expert_start,
                     item.layer_span, item.layer_start, item.region_namespace};
      req_tuser  <= item.func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      lookup_results_q.insert(lookup_results_q.size(), table_step(item));
      if (steady_sender || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Stops offering words until every response already due has arrived.
   task automatic wait_for_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (lookup_results_q.size() != 0) @(posedge clock);
   endtask

   // Each cause of an invalid region on its own, and a region whose ends sit
   // exactly at the top of the range, which is legal.
   task automatic test_invalid_regions();
      send_word(add_word(32'd0, 32'd0, 32'd4, 32'd0, 32'd4, 16'h0001, 1'b1));
      send_word(add_word(32'd1, 32'd0, 32'd0, 32'd0, 32'd4, 16'h0001, 1'b1));
      send_word(add_word(32'd1, 32'd0, 32'd4, 32'd0, 32'd0, 16'h0001, 1'b1));
      send_word(add_word(32'd1, 32'd0, 32'd4, 32'd0, 32'd4, 16'h0001, 1'b0));
      send_word(add_word(32'd1, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd4, 16'h0001, 1'b1));
      send_word(add_word(32'd1, 32'd0, 32'd4, 32'd1, 32'hFFFF_FFFF, 16'h0001, 1'b1));
      send_word(add_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                         16'h5A5A, 1'b1));
   endtask

   // Adjacent regions are accepted, shared cells are refused, and the same
   // region in another namespace does not clash.
   task automatic test_region_adds();
      send_word(add_word(32'd1, 32'd10, 32'd10, 32'd0, 32'd8, 16'hFFFF, 1'b1));
      send_word(add_word(32'd1, 32'd20, 32'd10, 32'd0, 32'd8, 16'h00A5, 1'b1));
      send_word(add_word(32'd1, 32'd19, 32'd2, 32'd7, 32'd2, 16'h0BAD, 1'b1));
      send_word(add_word(32'd2, 32'd10, 32'd10, 32'd0, 32'd8, 16'h0000, 1'b1));
      send_word(add_word(32'd1, 32'd0, 32'd10, 32'd8, 32'd8, 16'h1357, 1'b1));
      send_word(add_word(32'd1, 32'd5, 32'd20, 32'd8, 32'd1, 16'h0BAD, 1'b1));
      send_word(add_word(32'd3, 32'hFFFF_FFFE, 32'd1, 32'd0, 32'hFFFF_FFFF,
                         16'h1234, 1'b1));
   endtask

   // Keys on the corners and just past the edges of the stored regions, a key
   // in namespace zero and a key at the very top of the range.
   task automatic test_key_finds();
      send_word(find_word(32'd1, 32'd10, 32'd0));
      send_word(find_word(32'd1, 32'd19, 32'd7));
      send_word(find_word(32'd1, 32'd20, 32'd0));
      send_word(find_word(32'd1, 32'd30, 32'd0));
      send_word(find_word(32'd1, 32'd9, 32'd0));
      send_word(find_word(32'd0, 32'd10, 32'd0));
      send_word(find_word(32'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFE));
      send_word(find_word(32'd3, 32'hFFFF_FFFF, 32'd0));
      send_word(find_word(32'd2, 32'd10, 32'd0));
      send_word(find_word(32'hFFFF_FFFF, 32'd0, 32'd0));
   endtask

   // Mostly well-formed adds in a few crowded namespaces and finds aimed at the
   // edges of stored regions, with malformed and wholly random words mixed in.
   task automatic test_random_traffic(input int count);
      rot_req_type w;
      int          roll;
      int          pick;
      logic [31:0] ns;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         ns   = 32'($urandom_range(1, 4));
         if (roll < 26) begin
            w = add_word(ns, $urandom_range(0, 255), $urandom_range(1, 32),
                         $urandom_range(0, 63), $urandom_range(1, 16),
                         16'($urandom()), 1'b1);
            // Six of the 26 add rolls break the add in one way each.
            if (roll >= 20) begin
               case ($urandom_range(0, 4))
                  0: w.region_namespace = 32'd0;
                  1: w.layer_span = 32'd0;
                  2: w.expert_span = 32'd0;
                  3: w.owner_usable = 1'b0;
                  default: begin
                     w.expert_start = $urandom_range(32'hFFFF_FE00, 32'hFFFF_FFFF);
                     w.expert_span  = $urandom_range(1, 1024);
                  end
               endcase
            end
         end else if (roll < 32) begin
            w = random_word();
         end else if (roll < 82 && region_count > 0) begin
            pick = $urandom_range(0, region_count - 1);
            w = find_word(region_ns[pick],
                          key_near(region_layer_lo[pick], region_layer_hi[pick]),
                          key_near(region_expert_lo[pick], region_expert_hi[pick]));
         end else begin
            w = find_word(ns, $urandom_range(0, 300), $urandom_range(0, 80));
         end
         send_word(w);
         if (n % 200 == 199) wait_for_results();
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // words back to back, so the block stalls its input; afterwards the sender
   // waits until the backlog has drained.
   task automatic test_backpressure();
      wait_for_results();
      steady_sender = 1'b1;
      hold_request  = HOLD_CYCLES;
      for (int n = 0; n < 12; n++) begin
         if (n % 3 == 2 || region_count == 0) begin
            send_word(random_word());
         end else begin
            send_word(find_word(region_ns[n % region_count],
                                region_layer_lo[n % region_count],
                                region_expert_lo[n % region_count]));
         end
      end
      steady_sender = 1'b0;
      wait_for_results();
   endtask

   // Fills whatever room is left, then shows that a full table is reported
   // only after the invalid and overlap checks.
   task automatic test_table_full();
      int k;
      k = 0;
      while (region_count < TABLE_DEPTH && k < 4 * TABLE_DEPTH) begin
         send_word(add_word(32'hFFFF_FFFE, 32'(k * 4), 32'd2, 32'd0, 32'd1,
                            16'(k), 1'b1));
         k++;
      end
      send_word(add_word(32'hFFFF_FFFE, 32'h4000_0000, 32'd1, 32'd0, 32'd1,
                         16'hBEEF, 1'b1));
      send_word(add_word(32'd1, 32'd10, 32'd1, 32'd0, 32'd1, 16'hBEEF, 1'b1));
      send_word(add_word(32'd0, 32'h4000_0000, 32'd1, 32'd0, 32'd1, 16'hBEEF, 1'b1));
      send_word(find_word(32'hFFFF_FFFE, 32'd1, 32'd0));
      send_word(find_word(32'hFFFF_FFFE, 32'h4000_0000, 32'd0));
   endtask

   // Response side: a long hold when a test asks for one, otherwise a randomly
   // picked pacing mode that is drawn anew whenever its run ends.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request != 0 || hold_left != 0) begin
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            pace_mode = pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(16, 200);
         end
         pace_left--;
         case (pace_mode)
            PACE_ALWAYS: rsp_tready <= 1'b1;
            PACE_COIN:   rsp_tready <= 1'($urandom());
            PACE_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= (pace_left % 5) != 0;
         endcase
      end
   end

   // Compares every accepted response word with the oldest prediction.
   always @(posedge clock) begin : check_response
      rot_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lookup_results_q.size() == 0) begin
            $error("response word %h with no request outstanding", rsp_tdata);
            mismatch_count++;
         end else begin
            want = lookup_results_q.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2] != want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tdata[2]);
               mismatch_count++;
            end
            if (rsp_tdata[18:3] != want.found_owner) begin
               $error("found_owner: expected %h, got %h", want.found_owner,
                      rsp_tdata[18:3]);
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("range_owner_table: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_invalid_regions();
      test_region_adds();
      test_key_finds();
      test_random_traffic(750);
      test_backpressure();
      test_table_full();
      wait_for_results();
      // Give a stray extra response word the chance to show itself.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && lookup_results_q.size() == 0) begin
         $display("range_owner_table: match");
      end else begin
         $display("range_owner_table: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
